FILE: rtl/kvc_pkg.sv
// ----------------------------------------------------------------------------
// kvc_pkg
// Item types and operation codes for the keyed value cache table.
// ----------------------------------------------------------------------------
package kvc_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_INVAL  = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [63:0]        tag_key;
        logic [31:0]        element_index;
        logic [63:0]        payload;
        logic signed [63:0] timestamp_ms;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic               status;
        logic               hit;
        logic [63:0]        read_value;
        logic signed [63:0] read_time_ms;
    } t_out_item;

endpackage

FILE: rtl/keyed_value_cache_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_value_cache_table_unit
// Fixed-capacity table of cached values keyed by tag key and element index.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on i_in_valid / o_in_ready / i_in and each one yields
// exactly one result item on o_out_valid / i_out_ready / o_out.
// Put stores or updates an entry, lookup returns the stored value and time,
// invalidate clears every used entry with the same tag key.
// Every operation scans the slots in use one per cycle through the read
// port of the entry memory, then checks the last entry read and leaves the
// scan. It then does the write-back or the decision in S_WRITE and loads
// the result register in S_DONE. On an empty table the scan reads no slot,
// and an unused opcode skips the scan. The next item is accepted once the
// previous one has reached the result register.
// The result register decouples the receiver: while it stalls, the block
// still accepts and processes one further item, which then waits.
// Reset clears the fill count and the control state; the entry memory
// needs no clearing pass because only slots below the fill count are read.
// ----------------------------------------------------------------------------
module keyed_value_cache_table_unit #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kvc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kvc_pkg::t_out_item o_out
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] ENT_CNT = CW'(ENTRIES);

    // One memory word per slot.
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [31:0]           element;
        logic [VALUE_BITS-1:0] payload;
        logic signed [63:0]    stamp;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;

    // Entry memory and its registered read data.
    t_entry r_mem [ENTRIES];
    t_entry r_rd;

    // Request held for the duration of the item.
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [31:0]           r_elem;
    logic [VALUE_BITS-1:0] r_val;
    logic signed [63:0]    r_now;

    // Scan bookkeeping.
    logic [CW-1:0]         r_used;
    logic [CW-1:0]         r_addr;
    logic                  r_pend;
    logic [AW-1:0]         r_pend_idx;
    logic                  r_hit;
    logic [AW-1:0]         r_hit_idx;
    logic                  r_free;
    logic [AW-1:0]         r_free_idx;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic signed [63:0]    r_hit_time;

    // Result waiting for the output register, and the output register.
    kvc_pkg::t_out_item    r_res;
    kvc_pkg::t_out_item    r_out;
    logic                  r_out_valid;
    kvc_pkg::t_out_item    n_res;
    logic                  n_out_valid;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    t_entry                wr_data;
    logic                  entry_match;
    logic                  is_put;
    logic                  room_left;

    // Read and write port control.
    always_comb begin
        rd_en       = (r_state == S_SCAN) && (r_addr < r_used);
        rd_addr     = r_addr[AW-1:0];
        entry_match = r_rd.valid && (r_rd.key == r_key) && (r_rd.element == r_elem);
        is_put      = (r_op == kvc_pkg::OP_PUT);
        room_left   = (r_used < ENT_CNT);
        wr_en       = 1'b0;
        wr_addr     = r_pend_idx;
        wr_data     = r_rd;
        if (r_state == S_SCAN) begin
            // Invalidate clears the entry that was just read if its tag key matches.
            wr_en         = r_pend && (r_op == kvc_pkg::OP_INVAL) && (r_rd.key == r_key);
            wr_addr       = r_pend_idx;
            wr_data       = r_rd;
            wr_data.valid = 1'b0;
        end else if (r_state == S_WRITE && is_put) begin
            // Put goes to the matching slot, the first free slot or a new one.
            wr_en           = r_hit || r_free || room_left;
            wr_data.valid   = 1'b1;
            wr_data.key     = r_key;
            wr_data.element = r_elem;
            wr_data.payload = r_val;
            wr_data.stamp   = r_now;
            if (r_hit) begin
                wr_addr = r_hit_idx;
            end else if (r_free) begin
                wr_addr = r_free_idx;
            end else begin
                wr_addr = r_used[AW-1:0];
            end
        end
    end

    // Result of the current item and the next state of the output register.
    always_comb begin
        n_res = '0;
        if (is_put) begin
            n_res.hit    = r_hit;
            n_res.status = !r_hit && !r_free && !room_left;
        end else if (r_op == kvc_pkg::OP_LOOKUP && r_hit) begin
            n_res.hit          = 1'b1;
            n_res.read_value   = 64'(r_hit_val);
            n_res.read_time_ms = r_hit_time;
        end
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            n_out_valid = 1'b1;
        end
    end

    // Entry memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Sequencer, scan bookkeeping and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The receiver frees the output register, a finished item fills it.
            r_out_valid <= n_out_valid;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op   <= i_in.opcode;
                        r_key  <= i_in.tag_key[KEY_BITS-1:0];
                        r_elem <= i_in.element_index;
                        r_val  <= i_in.payload[VALUE_BITS-1:0];
                        r_now  <= i_in.timestamp_ms;
                        r_addr <= '0;
                        r_pend <= 1'b0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        if (i_in.opcode == kvc_pkg::OP_PUT ||
                            i_in.opcode == kvc_pkg::OP_LOOKUP ||
                            i_in.opcode == kvc_pkg::OP_INVAL) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end

                S_SCAN: begin
                    // Issue the next read.
                    r_pend     <= rd_en;
                    r_pend_idx <= rd_addr;
                    if (rd_en) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    // Check the entry read in the previous cycle.
                    if (r_pend) begin
                        if (entry_match && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_pend_idx;
                            r_hit_val  <= r_rd.payload;
                            r_hit_time <= r_rd.stamp;
                        end
                        if (!r_rd.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_pend_idx;
                        end
                    end
                    if (!rd_en && !r_pend) begin
                        r_state <= S_WRITE;
                    end
                end

                S_WRITE: begin
                    // Decide the result; the put write happens in this cycle.
                    r_res <= n_res;
                    if (is_put && !r_hit && !r_free && room_left) begin
                        r_used <= r_used + CW'(1);
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // Load the result once the output register is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The fill count never passes the capacity.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ENT_CNT)
        else $error("fill count exceeds capacity");

    // The fill count grows by one slot at a time.
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + CW'(1)))
        else $error("fill count jumped");

    // A write never targets the entry being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write to the same entry");

    // The scan address never runs past the slots in use.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_used))
        else $error("scan ran past the used slots");

    // A full table and a hit never appear together in one result.
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.status && o_out.hit))
        else $error("full status together with hit");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed value cache table.
// A shadow copy of the table predicts the result of every accepted request.
// Each delivered result is compared field by field, in order, with that
// prediction. Stimulus starts with a directed sequence and continues with
// random puts, lookups, invalidates and a few unused opcodes over a small
// pool of keys. The pool is small enough that entries get updated, refilled
// and the table fills up. Both handshakes stall in random bursts.
// ----------------------------------------------------------------------------
module tb;

    localparam int          ENTRIES    = 64;
    localparam int          KEY_BITS   = 64;
    localparam int          VALUE_BITS = 64;
    localparam logic [63:0] KEY_MASK   = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 1);
    localparam logic [63:0] VALUE_MASK = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 1);
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          TAG_POOL   = 8;
    localparam int          ELEM_POOL  = 12;

    // Shadow copy of the table and the queue of predicted results.
    class kvc_shadow_table;
        logic               slot_valid   [ENTRIES];
        logic [63:0]        slot_key     [ENTRIES];
        logic [31:0]        slot_element [ENTRIES];
        logic [63:0]        slot_value   [ENTRIES];
        logic signed [63:0] slot_time    [ENTRIES];
        int                 fill_count;
        int                 errors;
        kvc_pkg::t_out_item pending_results[$];

        function new();
            fill_count = 0;
            errors = 0;
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        endfunction

        // First valid slot in use that holds this key, or -1.
        function int find_match(logic [63:0] key, logic [31:0] elem);
            for (int i = 0; i < fill_count; i++) begin
                if (slot_valid[i] && slot_key[i] == key && slot_element[i] == elem)
                    return i;
            end
            return -1;
        endfunction

        // Works out the result of one request and updates the shadow table.
        function kvc_pkg::t_out_item predict_result(kvc_pkg::t_in_item req);
            kvc_pkg::t_out_item res;
            logic [63:0]        key;
            int                 slot;
            res = '0;
            key = req.tag_key & KEY_MASK;
            case (req.opcode)
                kvc_pkg::OP_PUT: begin
                    slot = find_match(key, req.element_index);
                    if (slot >= 0) begin
                        slot_value[slot] = req.payload & VALUE_MASK;
                        slot_time[slot] = req.timestamp_ms;
                        res.hit = 1'b1;
                    end else begin
                        // Refill the first hole, else append, else report full.
                        slot = -1;
                        for (int i = 0; i < fill_count; i++) begin
                            if (!slot_valid[i] && slot < 0)
                                slot = i;
                        end
                        if (slot < 0 && fill_count < ENTRIES) begin
                            slot = fill_count;
                            fill_count++;
                        end
                        if (slot < 0) begin
                            res.status = 1'b1;
                        end else begin
                            slot_key[slot] = key;
                            slot_element[slot] = req.element_index;
                            slot_value[slot] = req.payload & VALUE_MASK;
                            slot_time[slot] = req.timestamp_ms;
                            slot_valid[slot] = 1'b1;
                        end
                    end
                end
                kvc_pkg::OP_LOOKUP: begin
                    slot = find_match(key, req.element_index);
                    if (slot >= 0) begin
                        res.hit = 1'b1;
                        res.read_value = slot_value[slot];
                        res.read_time_ms = slot_time[slot];
                    end
                end
                kvc_pkg::OP_INVAL: begin
                    for (int i = 0; i < fill_count; i++) begin
                        if (slot_key[i] == key)
                            slot_valid[i] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            return res;
        endfunction

        function void note_request(kvc_pkg::t_in_item req);
            pending_results.push_back(predict_result(req));
        endfunction

        function void check_result(kvc_pkg::t_out_item got);
            kvc_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            end
            if (got.hit !== want.hit) begin
                errors++;
                $display("%0t: hit expected %0d, got %0d", $time, want.hit, got.hit);
            end
            if (got.read_value !== want.read_value) begin
                errors++;
                $display("%0t: read_value expected %h, got %h", $time,
                         want.read_value, got.read_value);
            end
            if (got.read_time_ms !== want.read_time_ms) begin
                errors++;
                $display("%0t: read_time_ms expected %0d, got %0d", $time,
                         want.read_time_ms, got.read_time_ms);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    kvc_pkg::t_in_item  i_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    kvc_pkg::t_out_item o_out;

    kvc_shadow_table board = new();
    logic            burst_idle = 1'b1;
    int              cycle_count = 0;
    logic [63:0]     tag_pool  [TAG_POOL];
    logic [31:0]     elem_pool [ELEM_POOL];

    keyed_value_cache_table_unit #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Note accepted requests and check delivered results at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_request(i_in);
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_out);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: ready with random stall bursts while idling is enabled.
    initial begin : result_sink
        int span;
        @(posedge i_clk);
        forever begin
            if (burst_idle && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 17);
            end else begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 12);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    function automatic kvc_pkg::t_in_item make_request(logic [1:0] op, logic [63:0] key,
                                                       logic [31:0] elem, logic [63:0] value,
                                                       logic signed [63:0] stamp);
        kvc_pkg::t_in_item req;
        req.opcode = op;
        req.tag_key = key;
        req.element_index = elem;
        req.payload = value;
        req.timestamp_ms = stamp;
        return req;
    endfunction

    // Random request over the key pools, with a little fully random noise.
    function automatic kvc_pkg::t_in_item random_request(int put_pct, int inval_pct);
        kvc_pkg::t_in_item req;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < put_pct)
            req.opcode = kvc_pkg::OP_PUT;
        else if (roll < put_pct + inval_pct)
            req.opcode = kvc_pkg::OP_INVAL;
        else if (roll < 98)
            req.opcode = kvc_pkg::OP_LOOKUP;
        else
            req.opcode = OP_UNUSED;
        if ($urandom_range(0, 19) == 0) begin
            req.tag_key = {$urandom, $urandom};
            req.element_index = $urandom;
        end else begin
            req.tag_key = tag_pool[$urandom_range(0, TAG_POOL - 1)];
            req.element_index = elem_pool[$urandom_range(0, ELEM_POOL - 1)];
        end
        case ($urandom_range(0, 19))
            0:       req.payload = '0;
            1:       req.payload = '1;
            default: req.payload = {$urandom, $urandom};
        endcase
        req.timestamp_ms = {$urandom, $urandom};
        return req;
    endfunction

    // Offer one request and hold it until it is accepted.
    task automatic send_request(input kvc_pkg::t_in_item req);
        int gap;
        if (burst_idle && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    task automatic send_random(int count, int put_pct, int inval_pct);
        for (int n = 0; n < count; n++)
            send_request(random_request(put_pct, inval_pct));
    endtask

    localparam logic [63:0] KMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] EMAX = 32'hFFFF_FFFF;
    localparam logic signed [63:0] TMIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    initial begin
        tag_pool[0] = '0;
        tag_pool[1] = KMAX;
        tag_pool[2] = 64'hAAAA_AAAA_AAAA_AAAA;
        tag_pool[3] = 64'h5555_5555_5555_5555;
        for (int i = 4; i < TAG_POOL; i++) tag_pool[i] = {$urandom, $urandom};
        elem_pool[0] = '0;
        elem_pool[1] = EMAX;
        elem_pool[2] = 32'hAAAA_AAAA;
        elem_pool[3] = 32'h5555_5555;
        for (int i = 4; i < ELEM_POOL; i++) elem_pool[i] = $urandom_range(1, 40);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: misses on an empty table, update, refill of a hole,
        // invalidate of a whole tag, unused opcode, extreme field values.
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, EMAX, '0, '0));
        send_request(make_request(kvc_pkg::OP_INVAL, KMAX, '0, '0, '0));
        send_request(make_request(kvc_pkg::OP_PUT, KMAX, EMAX, KMAX, TMIN));
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, EMAX, '0, '0));
        send_request(make_request(kvc_pkg::OP_PUT, KMAX, EMAX, '0, TMAX));
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, EMAX, KMAX, TMIN));
        send_request(make_request(kvc_pkg::OP_PUT, '0, '0, 64'h8000_0000_0000_0001, -64'sd1));
        send_request(make_request(kvc_pkg::OP_PUT, '0, 32'd1, 64'h1234_5678_9ABC_DEF0, 64'sd5));
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, '0, '0, '0));
        send_request(make_request(kvc_pkg::OP_LOOKUP, '0, 32'd1, '0, '0));
        send_request(make_request(kvc_pkg::OP_INVAL, '0, EMAX, KMAX, TMAX));
        send_request(make_request(kvc_pkg::OP_LOOKUP, '0, '0, '0, '0));
        send_request(make_request(kvc_pkg::OP_PUT, 64'd5, 32'd7, 64'hDEAD_BEEF, 64'sd77));
        send_request(make_request(kvc_pkg::OP_LOOKUP, 64'd5, 32'd7, '0, '0));
        send_request(make_request(OP_UNUSED, KMAX, EMAX, KMAX, TMAX));
        send_request(make_request(kvc_pkg::OP_INVAL, 64'd6, '0, '0, '0));
        send_request(make_request(kvc_pkg::OP_INVAL, KMAX, '0, '0, '0));
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, EMAX, '0, '0));
        send_request(make_request(kvc_pkg::OP_PUT, KMAX, EMAX, 64'h0F0F_0F0F_0F0F_0F0F, TMIN));
        send_request(make_request(kvc_pkg::OP_LOOKUP, KMAX, EMAX, '0, '0));

        // Fill phase: mostly puts, so the table reaches its capacity.
        send_random(160, 80, 0);
        burst_idle = 1'b0;
        send_random(40, 50, 5);
        // Churn phase: invalidates open holes that puts refill.
        burst_idle = 1'b1;
        send_random(140, 55, 12);
        burst_idle = 1'b0;
        send_random(60, 50, 10);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 16) @(posedge i_clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: sim.f
rtl/kvc_pkg.sv
rtl/keyed_value_cache_table_unit.sv
sim/tb.sv
